FILE: rtl/sspq_pkg.sv
// ============================================================================
// sspq_pkg : shared types and constants for the stable sorted priority queue
// Beat formats, command/status codes and controller-to-datapath signal groups.
// ============================================================================
package sspq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  priority_req;
        logic [15:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_priority;
        logic [15:0] out_tag;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the captured command to the cell array
    } t_dp_cmd;

endpackage

FILE: rtl/stable_sorted_priority_queue_top.sv
// ============================================================================
// stable_sorted_priority_queue_top : stable sorted priority queue
// Up to DEPTH (priority, tag) entries kept in ascending priority order.
// ============================================================================
// Each input beat is a command: insert (priority_req, tag) or remove the head.
// Inserts land after every stored entry of lower or equal priority, so equal
// priorities leave in arrival order. Every command returns exactly one result
// beat: inserted, removed (with the head's priority and tag), empty on remove,
// or full on insert (entry dropped, queue untouched). A command is first
// captured; then the cell array shifts and the result lands in the output
// register. A new command is accepted only once the previous one has
// executed. All cells compare against the new priority in parallel, so
// latency does not depend on fill. A held result beat stalls the execute
// phase, and no new command is captured while it waits.
// ============================================================================
module stable_sorted_priority_queue_top #(
    parameter int DEPTH     = sspq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = sspq_pkg::PRIO_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sspq_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sspq_pkg::t_out_item o_out_data
);
    import sspq_pkg::*;

    t_dp_cmd   w_dp_cmd;     // load / exec strobes to the cell array
    t_out_item w_dp_result;  // result computed from the captured command

    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_dp_cmd    (w_dp_cmd),
        .i_dp_result (w_dp_result)
    );

    sspq_dp #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (w_dp_cmd),
        .o_result  (w_dp_result)
    );

endmodule

FILE: rtl/sspq_ctrl.sv
// ============================================================================
// sspq_ctrl : handshake controller
// Accepts an input beat, steps the datapath, and holds the result beat.
// ============================================================================
module sspq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sspq_pkg::t_out_item o_out_data,
    output sspq_pkg::t_dp_cmd   o_dp_cmd,
    input  sspq_pkg::t_out_item i_dp_result
);
    import sspq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      w_slot_free;

    assign w_slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_dp_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_dp_cmd.exec = (r_state == S_EXEC) && w_slot_free;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result refills the slot; otherwise a taken beat empties it
            if (o_dp_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (o_dp_cmd.exec) begin
            r_out_data <= i_dp_result;
        end
    end

    // result only written into a free output slot
    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("exec with occupied output slot");

    // a captured beat is always followed by its execute phase
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.load |=> (r_state == S_EXEC))
        else $error("load not followed by exec state");

    // executing produces a result beat next cycle
    a_exec_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.exec |=> r_out_valid)
        else $error("exec did not produce a result");

endmodule

FILE: rtl/sspq_dp.sv
// ============================================================================
// sspq_dp : sorted cell array datapath
// Row of cells kept in ascending priority order; insert shifts up, remove down.
// ============================================================================
module sspq_dp #(
    parameter int DEPTH     = sspq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = sspq_pkg::PRIO_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sspq_pkg::t_in_item  i_in_data,
    input  sspq_pkg::t_dp_cmd   i_cmd,
    output sspq_pkg::t_out_item o_result
);
    import sspq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_in_item             r_req;
    logic [PRIO_BITS-1:0] r_prio [DEPTH];
    logic [15:0]          r_tag  [DEPTH];
    logic [CNT_W-1:0]     r_count;

    logic [31:0]          w_pr_ext;
    logic [PRIO_BITS-1:0] w_pr;
    logic [31:0]          w_head_ext;
    logic [DEPTH-1:0]     w_gt;     // cell holds a larger priority, or is beyond the tail
    logic [DEPTH-1:0]     w_prev;   // left neighbor's w_gt
    logic                 w_full;
    logic                 w_empty;
    logic                 w_do_ins;
    logic                 w_do_rem;

    assign w_pr_ext   = 32'(r_req.priority_req);
    assign w_pr       = w_pr_ext[PRIO_BITS-1:0];
    assign w_head_ext = 32'(r_prio[0]);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_do_ins   = i_cmd.exec && (r_req.command == CMD_INSERT) && !w_full;
    assign w_do_rem   = i_cmd.exec && (r_req.command == CMD_REMOVE) && !w_empty;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) ? (r_prio[i] > w_pr) : 1'b1;
        end
    end
    assign w_prev = {w_gt[DEPTH-2:0], 1'b0};

    always_comb begin
        o_result = '0;
        if (r_req.command == CMD_INSERT) begin
            o_result.status = w_full ? ST_FULL : ST_INSERTED;
        end else if (w_empty) begin
            o_result.status = ST_EMPTY;
        end else begin
            o_result.status       = ST_REMOVED;
            o_result.out_priority = w_head_ext[7:0];
            o_result.out_tag      = r_tag[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_do_ins) begin
            r_count <= r_count + CNT_W'(1);
        end else if (w_do_rem) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
        if (w_do_ins) begin
            if (w_gt[0]) begin
                r_prio[0] <= w_pr;
                r_tag[0]  <= r_req.tag;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (w_prev[i]) begin
                    r_prio[i] <= r_prio[i-1];
                    r_tag[i]  <= r_tag[i-1];
                end else if (w_gt[i]) begin
                    r_prio[i] <= w_pr;
                    r_tag[i]  <= r_req.tag;
                end
            end
        end else if (w_do_rem) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_prio[i] <= r_prio[i+1];
                r_tag[i]  <= r_tag[i+1];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not bump count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_prio[0] <= r_prio[1]))
        else $error("head cells out of order");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb : self-checking bench for stable_sorted_priority_queue_top
// Sends insert and remove command beats and predicts every result beat with a
// sorted shadow list that keeps equal priorities in arrival order. Each result
// beat is checked field by field against the oldest prediction. Both sides
// idle at random, and the result side holds off once for a long stretch.
// ============================================================================
module tb;
    import sspq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;   // cycles with no accepted beat
    localparam int HOLD_CYCLES = 300;    // long result-side hold-off
    localparam int HOLD_AFTER  = 150;    // results seen before that hold-off
    localparam int RAND_ITEMS  = 828;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_beat  = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_data;

    // queue contents as the block should hold them, head at index 0
    logic [7:0]  shadow_prio [QDEPTH];
    logic [15:0] shadow_tag  [QDEPTH];
    int          shadow_count = 0;

    t_in_item  pending_cmds[$];
    t_out_item expected_results[$];

    int n_sent      = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int stall_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    stable_sorted_priority_queue_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the shadow list and return the result it gives.
    // Insert walks down from the tail and stops at the first entry whose
    // priority is not above the new one, so ties stay behind older entries.
    function automatic t_out_item queue_apply(input t_in_item c);
        t_out_item r = '0;
        int        i;
        if (c.command == CMD_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (i = shadow_count; i > 0 && shadow_prio[i-1] > c.priority_req; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_prio[i] = c.priority_req;
                shadow_tag[i]  = c.tag;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status       = ST_REMOVED;
            r.out_priority = shadow_prio[0];
            r.out_tag      = shadow_tag[0];
            for (i = 1; i < shadow_count; i++) begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_count--;
        end
        return r;
    endfunction

    task automatic add_cmd(input logic c, input logic [7:0] p, input logic [15:0] t);
        t_in_item it;
        it.command      = c;
        it.priority_req = p;
        it.tag          = t;
        pending_cmds.push_back(it);
    endtask

    // ------------------------------------------------------------------------
    // Command driver: a beat is retired on valid & ready; predict it then and
    // load the next one in the same branch so valid gets one update per edge.
    // Idles ~22% of the time, except for a stretch of beats in the middle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(queue_apply(in_beat));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_cmds.size() > 0 &&
                    ((n_sent >= 400 && n_sent < 600) || $urandom_range(0, 99) >= 22)) begin
                    in_valid <= 1'b1;
                    in_beat  <= pending_cmds.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side ready: random ~22% idle, a quiet stretch with no idle, and
    // one long hold-off so the result register fills and the block backs up
    // onto the command channel while the driver keeps offering beats.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (n_results >= 400 && n_results < 600) ||
                         ($urandom_range(0, 99) >= 22);
        end
    end

    // Result monitor: every accepted beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            n_results <= n_results + 1;
            if (expected_results.size() == 0) begin
                $error("result beat with no command outstanding: status %0d", o_out_data.status);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    n_errors++;
                end
                if (o_out_data.out_priority !== want.out_priority) begin
                    $error("out_priority: expected %0d, got %0d",
                           want.out_priority, o_out_data.out_priority);
                    n_errors++;
                end
                if (o_out_data.out_tag !== want.out_tag) begin
                    $error("out_tag: expected 0x%04h, got 0x%04h",
                           want.out_tag, o_out_data.out_tag);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: too long without any accepted beat on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("stable_sorted_priority_queue_top test failed");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          burst_len;
        int          insert_pct;
        int          pick;
        int          made;
        logic [7:0]  p;

        // directed: empty remove, ties, new head into a populated list,
        // field extremes, fill to full, insert on full, then a few removes
        add_cmd(CMD_REMOVE, 8'd0,   16'h0000);
        add_cmd(CMD_INSERT, 8'd200, 16'h0001);
        add_cmd(CMD_INSERT, 8'd200, 16'h0002);
        add_cmd(CMD_INSERT, 8'd10,  16'h0003);
        add_cmd(CMD_INSERT, 8'd255, 16'hFFFF);
        add_cmd(CMD_INSERT, 8'd0,   16'h0000);
        add_cmd(CMD_INSERT, 8'd0,   16'h8000);
        add_cmd(CMD_INSERT, 8'd255, 16'h7FFF);
        add_cmd(CMD_INSERT, 8'd128, 16'h5555);
        add_cmd(CMD_INSERT, 8'd127, 16'hAAAA);
        add_cmd(CMD_INSERT, 8'd10,  16'h0004);
        add_cmd(CMD_INSERT, 8'd200, 16'h0005);
        add_cmd(CMD_INSERT, 8'd1,   16'h1234);
        add_cmd(CMD_INSERT, 8'd254, 16'hFEDC);
        add_cmd(CMD_INSERT, 8'd64,  16'h00FF);
        add_cmd(CMD_INSERT, 8'd128, 16'hFF00);
        add_cmd(CMD_INSERT, 8'd10,  16'h0006);
        add_cmd(CMD_INSERT, 8'd5,   16'hDEAD);
        add_cmd(CMD_REMOVE, 8'hFF,  16'hFFFF);
        add_cmd(CMD_REMOVE, 8'h00,  16'h0000);
        add_cmd(CMD_REMOVE, 8'd0,   16'h0000);
        add_cmd(CMD_REMOVE, 8'd0,   16'h0000);

        // random bursts: insert-heavy, remove-heavy or balanced, so the queue
        // keeps swinging between empty and full; narrow priority bands force ties
        made = 0;
        while (made < RAND_ITEMS) begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            for (int k = 0; k < burst_len && made < RAND_ITEMS; k++) begin
                pick = $urandom_range(0, 3);
                if (pick == 0)      p = 8'($urandom_range(0, 3));
                else if (pick == 1) p = 8'($urandom_range(252, 255));
                else                p = 8'($urandom_range(0, 255));
                add_cmd(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                        p, 16'($urandom_range(0, 65535)));
                made++;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("stable_sorted_priority_queue_top test passed");
        end else begin
            $display("stable_sorted_priority_queue_top test failed");
        end
        $finish;
    end

endmodule
